// ===== src/assert_macros.svh =====
// Assertion helpers; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define MCS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define MCS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define MCS_ASSERT(lbl, prop)
`define MCS_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ===== src/mcs_pkg.sv =====
`default_nettype none

package mcs_pkg;

  localparam int MAX_DIM_DEF = 16;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EMIT  = 1'b1;

  localparam logic [2:0] REG_ROWS  = 3'd0;
  localparam logic [2:0] REG_COLS  = 3'd1;
  localparam logic [2:0] REG_LEFT  = 3'd2;
  localparam logic [2:0] REG_RIGHT = 3'd3;
  localparam logic [2:0] REG_UP    = 3'd4;
  localparam logic [2:0] REG_DOWN  = 3'd5;

  typedef enum logic [2:0] {
    OP_POS,
    OP_NL,
    OP_NU,
    OP_SL,
    OP_SR,
    OP_SU,
    OP_SD
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIX_POS,
    ST_FIX_LEFT,
    ST_FIX_UP,
    ST_SL,
    ST_SR,
    ST_SU,
    ST_SD,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [4:0]  row_count;
    logic [4:0]  col_count;
    logic [15:0] shift_left;
    logic [15:0] shift_right;
    logic [15:0] shift_up;
    logic [15:0] shift_down;
  } cfg_t;

  typedef struct packed {
    logic div_start;
    op_t  start_op;
    logic div_store;
    op_t  store_op;
    logic exec_in;
    logic exec_hold;
    logic hold_load;
    logic clear_stale;
  } cmd_t;

  typedef struct packed {
    logic stale;
    logic shifts_ready;
    logic hold_cmd;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== src/mcs_regs.sv =====
`default_nettype none

module mcs_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_psel,
  input  wire logic          cfg_penable,
  input  wire logic          cfg_pwrite,
  input  wire logic [4:0]    cfg_paddr,
  input  wire logic [31:0]   cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready,
  output mcs_pkg::cfg_t      cfg,
  output logic               dims_wr
);

  mcs_pkg::cfg_t cfg_r, cfg_nxt;
  logic          wr_en;
  logic [2:0]    idx;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign dims_wr    = wr_en && (idx == mcs_pkg::REG_ROWS || idx == mcs_pkg::REG_COLS);
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        mcs_pkg::REG_ROWS:  cfg_nxt.row_count   = cfg_pwdata[4:0];
        mcs_pkg::REG_COLS:  cfg_nxt.col_count   = cfg_pwdata[4:0];
        mcs_pkg::REG_LEFT:  cfg_nxt.shift_left  = cfg_pwdata[15:0];
        mcs_pkg::REG_RIGHT: cfg_nxt.shift_right = cfg_pwdata[15:0];
        mcs_pkg::REG_UP:    cfg_nxt.shift_up    = cfg_pwdata[15:0];
        mcs_pkg::REG_DOWN:  cfg_nxt.shift_down  = cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      mcs_pkg::REG_ROWS:  cfg_prdata = {27'd0, cfg_r.row_count};
      mcs_pkg::REG_COLS:  cfg_prdata = {27'd0, cfg_r.col_count};
      mcs_pkg::REG_LEFT:  cfg_prdata = {16'd0, cfg_r.shift_left};
      mcs_pkg::REG_RIGHT: cfg_prdata = {16'd0, cfg_r.shift_right};
      mcs_pkg::REG_UP:    cfg_prdata = {16'd0, cfg_r.shift_up};
      mcs_pkg::REG_DOWN:  cfg_prdata = {16'd0, cfg_r.shift_down};
      default:            cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_count   <= 5'd1;
      cfg_r.col_count   <= 5'd1;
      cfg_r.shift_left  <= '0;
      cfg_r.shift_right <= '0;
      cfg_r.shift_up    <= '0;
      cfg_r.shift_down  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/mcs_div.sv =====
`default_nettype none

module mcs_div #(
  parameter int NW = 16,
  parameter int DW = 5
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quot,
  output logic [DW-1:0]      rem
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] num_r, num_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {rem_r, num_r[NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};
  assign done  = done_r;
  assign quot  = num_r;
  assign rem   = rem_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NW);
      num_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      num_nxt = {num_r[NW-2:0], ge};
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

endmodule

`default_nettype wire

// ===== src/mcs_dp.sv =====
`default_nettype none

module mcs_dp #(
  parameter int MAX_DIM = mcs_pkg::MAX_DIM_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mcs_pkg::cfg_t    cfg,
  input  wire logic             dims_wr,
  input  wire mcs_pkg::cmd_t    cmd,
  output mcs_pkg::status_t      sts,
  input  wire logic             in_command,
  input  wire logic [31:0]      in_data,
  input  wire logic             out_tready,
  output logic                  out_tvalid,
  output logic [31:0]           out_tdata,
  output logic                  out_tlast
);

  localparam int DIMW  = $clog2(MAX_DIM + 1);
  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = $clog2(DEPTH + 1);
  localparam int NW    = (PW > 16) ? PW : 16;

  logic [31:0]   mem [DEPTH];

  logic [PW-1:0] pos_r, pos_nxt;
  logic [IW-1:0] lr_r, lr_nxt, lc_r, lc_nxt;
  logic [IW-1:0] er_r, er_nxt, ec_r, ec_nxt;
  logic [IW-1:0] nl_r, nl_nxt, nu_r, nu_nxt;
  logic [IW-1:0] rl_r, rl_nxt, rr_r, rr_nxt, ru_r, ru_nxt;
  logic          ready_r, ready_nxt;
  logic          stale_r, stale_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_last_r;
  logic [31:0]   out_data_r;
  logic          hold_cmd_r;
  logic [31:0]   hold_data_r;

  logic [DIMW-1:0] rows, cols;
  logic [PW-1:0]   total;
  logic            item_cmd;
  logic [31:0]     item_data;
  logic            do_exec, do_wr, do_rd;
  logic            wr_zero;
  logic [PW-1:0]   ld_pos;
  logic [IW-1:0]   ld_row, ld_col;
  logic [AW-1:0]   wr_addr, rd_addr;
  logic            em_zero;
  logic [IW-1:0]   em_row, em_col;
  logic [DIMW:0]   src_row_sum, src_col_sum;
  logic [IW-1:0]   src_row, src_col;
  logic            last;
  logic [DIMW:0]   net_l_sum, net_u_sum;

  logic [NW-1:0]   div_num;
  logic [DIMW-1:0] div_den;
  logic            div_done;
  logic [NW-1:0]   div_quot;
  logic [DIMW-1:0] div_rem;

  function automatic logic [DIMW-1:0] clamp_dim(input logic [4:0] v);
    if (v == 5'd0) return DIMW'(1);
    else if (32'(v) > MAX_DIM) return DIMW'(MAX_DIM);
    else return DIMW'(v);
  endfunction

  assign rows  = clamp_dim(cfg.row_count);
  assign cols  = clamp_dim(cfg.col_count);
  assign total = PW'(32'(rows) * 32'(cols));

  assign item_cmd  = cmd.exec_hold ? hold_cmd_r : in_command;
  assign item_data = cmd.exec_hold ? hold_data_r : in_data;
  assign do_exec   = cmd.exec_in || cmd.exec_hold;
  assign do_wr     = do_exec && (item_cmd == mcs_pkg::CMD_WRITE);
  assign do_rd     = do_exec && (item_cmd == mcs_pkg::CMD_EMIT);

  always_comb begin
    case (cmd.start_op)
      mcs_pkg::OP_POS: begin div_num = NW'(pos_r);          div_den = cols; end
      mcs_pkg::OP_NL:  begin div_num = NW'(nl_r);           div_den = cols; end
      mcs_pkg::OP_NU:  begin div_num = NW'(nu_r);           div_den = rows; end
      mcs_pkg::OP_SL:  begin div_num = NW'(cfg.shift_left);  div_den = cols; end
      mcs_pkg::OP_SR:  begin div_num = NW'(cfg.shift_right); div_den = cols; end
      mcs_pkg::OP_SU:  begin div_num = NW'(cfg.shift_up);    div_den = rows; end
      mcs_pkg::OP_SD:  begin div_num = NW'(cfg.shift_down);  div_den = rows; end
      default:         begin div_num = '0;                   div_den = cols; end
    endcase
  end

  mcs_div #(
    .NW (NW),
    .DW (DIMW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  // load position
  assign wr_zero = pos_r >= total;
  assign ld_pos  = wr_zero ? '0 : pos_r;
  assign ld_row  = wr_zero ? '0 : lr_r;
  assign ld_col  = wr_zero ? '0 : lc_r;
  assign wr_addr = AW'(32'(ld_row) * MAX_DIM + 32'(ld_col));

  // readout position
  assign em_zero     = !ready_r || (DIMW'(er_r) >= rows) || (DIMW'(ec_r) >= cols);
  assign em_row      = em_zero ? '0 : er_r;
  assign em_col      = em_zero ? '0 : ec_r;
  assign src_row_sum = (DIMW+1)'(em_row) + (DIMW+1)'(nu_r);
  assign src_col_sum = (DIMW+1)'(em_col) + (DIMW+1)'(nl_r);
  assign src_row     = IW'((src_row_sum >= (DIMW+1)'(rows)) ?
                           src_row_sum - (DIMW+1)'(rows) : src_row_sum);
  assign src_col     = IW'((src_col_sum >= (DIMW+1)'(cols)) ?
                           src_col_sum - (DIMW+1)'(cols) : src_col_sum);
  assign rd_addr     = AW'(32'(src_row) * MAX_DIM + 32'(src_col));
  assign last        = (DIMW'(em_row) == rows - DIMW'(1)) &&
                       (DIMW'(em_col) == cols - DIMW'(1));

  assign net_l_sum = (DIMW+1)'(rl_r) + (DIMW+1)'(cols) - (DIMW+1)'(rr_r);
  assign net_u_sum = (DIMW+1)'(ru_r) + (DIMW+1)'(rows) - (DIMW+1)'(div_rem);

  always_comb begin
    pos_nxt       = pos_r;
    lr_nxt        = lr_r;
    lc_nxt        = lc_r;
    er_nxt        = er_r;
    ec_nxt        = ec_r;
    nl_nxt        = nl_r;
    nu_nxt        = nu_r;
    rl_nxt        = rl_r;
    rr_nxt        = rr_r;
    ru_nxt        = ru_r;
    ready_nxt     = ready_r;
    stale_nxt     = stale_r;
    out_valid_nxt = out_valid_r && !out_tready;

    if (cmd.div_store) begin
      case (cmd.store_op)
        mcs_pkg::OP_POS: begin
          lr_nxt = IW'(div_quot);
          lc_nxt = IW'(div_rem);
        end
        mcs_pkg::OP_NL: nl_nxt = IW'(div_rem);
        mcs_pkg::OP_NU: nu_nxt = IW'(div_rem);
        mcs_pkg::OP_SL: rl_nxt = IW'(div_rem);
        mcs_pkg::OP_SR: rr_nxt = IW'(div_rem);
        mcs_pkg::OP_SU: ru_nxt = IW'(div_rem);
        mcs_pkg::OP_SD: begin
          nl_nxt    = IW'((net_l_sum >= (DIMW+1)'(cols)) ?
                          net_l_sum - (DIMW+1)'(cols) : net_l_sum);
          nu_nxt    = IW'((net_u_sum >= (DIMW+1)'(rows)) ?
                          net_u_sum - (DIMW+1)'(rows) : net_u_sum);
          ready_nxt = 1'b1;
          er_nxt    = '0;
          ec_nxt    = '0;
        end
        default: ;
      endcase
    end

    if (cmd.clear_stale) stale_nxt = 1'b0;
    if (dims_wr) stale_nxt = 1'b1;

    if (do_wr) begin
      ready_nxt = 1'b0;
      er_nxt    = '0;
      ec_nxt    = '0;
      if ((PW+1)'(ld_pos) + (PW+1)'(1) >= (PW+1)'(total)) begin
        pos_nxt = '0;
        lr_nxt  = '0;
        lc_nxt  = '0;
      end else if (DIMW'(ld_col) + DIMW'(1) >= cols) begin
        pos_nxt = ld_pos + PW'(1);
        lr_nxt  = ld_row + IW'(1);
        lc_nxt  = '0;
      end else begin
        pos_nxt = ld_pos + PW'(1);
        lr_nxt  = ld_row;
        lc_nxt  = ld_col + IW'(1);
      end
    end

    if (do_rd) begin
      out_valid_nxt = 1'b1;
      if (last) begin
        er_nxt    = '0;
        ec_nxt    = '0;
        ready_nxt = 1'b0;
      end else if (DIMW'(em_col) + DIMW'(1) >= cols) begin
        er_nxt = em_row + IW'(1);
        ec_nxt = '0;
      end else begin
        er_nxt = em_row;
        ec_nxt = em_col + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      lr_r        <= '0;
      lc_r        <= '0;
      er_r        <= '0;
      ec_r        <= '0;
      nl_r        <= '0;
      nu_r        <= '0;
      ready_r     <= 1'b0;
      stale_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      lr_r        <= lr_nxt;
      lc_r        <= lc_nxt;
      er_r        <= er_nxt;
      ec_r        <= ec_nxt;
      nl_r        <= nl_nxt;
      nu_r        <= nu_nxt;
      ready_r     <= ready_nxt;
      stale_r     <= stale_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rl_r <= rl_nxt;
    rr_r <= rr_nxt;
    ru_r <= ru_nxt;
    if (cmd.hold_load) begin
      hold_cmd_r  <= in_command;
      hold_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_addr] <= item_data;
  end

  always_ff @(posedge clk) begin
    if (do_rd) begin
      out_data_r <= mem[rd_addr];
      out_last_r <= last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  assign sts.stale        = stale_r;
  assign sts.shifts_ready = ready_r;
  assign sts.hold_cmd     = hold_cmd_r;
  assign sts.div_done     = div_done;
  assign sts.out_free     = !out_valid_r || out_tready;

endmodule

`default_nettype wire

// ===== src/mcs_ctrl.sv =====
`default_nettype none

`include "assert_macros.svh"

module mcs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  input  wire logic              in_command,
  output logic                   in_tready,
  input  wire mcs_pkg::status_t  sts,
  output mcs_pkg::cmd_t          cmd
);

  mcs_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      mcs_pkg::ST_IDLE: begin
        in_tready = sts.out_free;
        if (in_tvalid && sts.out_free) begin
          if (!sts.stale &&
              (in_command == mcs_pkg::CMD_WRITE || sts.shifts_ready)) begin
            cmd.exec_in = 1'b1;
          end else begin
            cmd.hold_load = 1'b1;
            cmd.div_start = 1'b1;
            if (sts.stale) begin
              cmd.start_op = mcs_pkg::OP_POS;
              state_nxt    = mcs_pkg::ST_FIX_POS;
            end else begin
              cmd.start_op = mcs_pkg::OP_SL;
              state_nxt    = mcs_pkg::ST_SL;
            end
          end
        end
      end
      mcs_pkg::ST_FIX_POS: begin
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          cmd.store_op  = mcs_pkg::OP_POS;
          cmd.div_start = 1'b1;
          cmd.start_op  = mcs_pkg::OP_NL;
          state_nxt     = mcs_pkg::ST_FIX_LEFT;
        end
      end
      mcs_pkg::ST_FIX_LEFT: begin
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          cmd.store_op  = mcs_pkg::OP_NL;
          cmd.div_start = 1'b1;
          cmd.start_op  = mcs_pkg::OP_NU;
          state_nxt     = mcs_pkg::ST_FIX_UP;
        end
      end
      mcs_pkg::ST_FIX_UP: begin
        if (sts.div_done) begin
          cmd.div_store   = 1'b1;
          cmd.store_op    = mcs_pkg::OP_NU;
          cmd.clear_stale = 1'b1;
          if (sts.hold_cmd == mcs_pkg::CMD_WRITE || sts.shifts_ready) begin
            state_nxt = mcs_pkg::ST_EXEC;
          end else begin
            cmd.div_start = 1'b1;
            cmd.start_op  = mcs_pkg::OP_SL;
            state_nxt     = mcs_pkg::ST_SL;
          end
        end
      end
      mcs_pkg::ST_SL: begin
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          cmd.store_op  = mcs_pkg::OP_SL;
          cmd.div_start = 1'b1;
          cmd.start_op  = mcs_pkg::OP_SR;
          state_nxt     = mcs_pkg::ST_SR;
        end
      end
      mcs_pkg::ST_SR: begin
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          cmd.store_op  = mcs_pkg::OP_SR;
          cmd.div_start = 1'b1;
          cmd.start_op  = mcs_pkg::OP_SU;
          state_nxt     = mcs_pkg::ST_SU;
        end
      end
      mcs_pkg::ST_SU: begin
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          cmd.store_op  = mcs_pkg::OP_SU;
          cmd.div_start = 1'b1;
          cmd.start_op  = mcs_pkg::OP_SD;
          state_nxt     = mcs_pkg::ST_SD;
        end
      end
      mcs_pkg::ST_SD: begin
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          cmd.store_op  = mcs_pkg::OP_SD;
          state_nxt     = mcs_pkg::ST_EXEC;
        end
      end
      mcs_pkg::ST_EXEC: begin
        if (sts.out_free) begin
          cmd.exec_hold = 1'b1;
          state_nxt     = mcs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mcs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mcs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `MCS_ASSERT(a_fast_clean, cmd.exec_in |-> (state_r == mcs_pkg::ST_IDLE) && !sts.stale)
  `MCS_ASSERT_NEXT(a_sd_exec, (state_r == mcs_pkg::ST_SD) && sts.div_done, state_r == mcs_pkg::ST_EXEC)
  `MCS_ASSERT_NEXT(a_div_busy, cmd.div_start, !sts.div_done)
  `MCS_ASSERT(a_done_ctx, sts.div_done |-> (state_r != mcs_pkg::ST_IDLE) && (state_r != mcs_pkg::ST_EXEC))

endmodule

`default_nettype wire

// ===== src/matrix_cyclic_shift.sv =====
// Write stored when it executes; emit result appears in the cycle after it executes.
// Throughput: one transaction per cycle while shifts are latched and output is free.
// First emit of a readout: four serial remainders run before it executes.
// After a row or column count write the next transaction adds three remainders.
// Reset: synchronous, active low; clears control state, matrix contents undefined.
`default_nettype none

module matrix_cyclic_shift #(
  parameter int MAX_DIM = mcs_pkg::MAX_DIM_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic signed [31:0] in_tdata,   // [31:0] element_in
  input  wire logic               in_tuser,   // [0] command
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic signed [31:0]      out_tdata,  // [31:0] element_out
  output logic                    out_tlast,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [4:0]         cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);

  mcs_pkg::cfg_t    cfg;
  mcs_pkg::cmd_t    cmd;
  mcs_pkg::status_t sts;
  logic             dims_wr;

  mcs_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg),
    .dims_wr     (dims_wr)
  );

  mcs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_command (in_tuser),
    .in_tready  (in_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  mcs_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .dims_wr    (dims_wr),
    .cmd        (cmd),
    .sts        (sts),
    .in_command (in_tuser),
    .in_data    (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int MAX_DIM   = mcs_pkg::MAX_DIM_DEF;
  localparam int SETTLE    = 200;
  localparam int LIMIT     = 1_000_000;
  localparam int HOLD_LEN  = 300;
  localparam int ITEM_GOAL = 1150;

  typedef struct packed {
    logic [31:0] element;
    logic        last;
  } shifted_elem_t;

  class shift_scoreboard;
    logic [4:0]  rows_reg;
    logic [4:0]  cols_reg;
    logic [15:0] left_reg;
    logic [15:0] right_reg;
    logic [15:0] up_reg;
    logic [15:0] down_reg;
    logic [31:0] store [MAX_DIM*MAX_DIM];
    bit          loaded [MAX_DIM*MAX_DIM];
    int unsigned load_pos;
    int unsigned emit_r;
    int unsigned emit_c;
    int unsigned net_left;
    int unsigned net_up;
    bit          latched;
    shifted_elem_t expected_q[$];
    int unsigned writes_seen;
    int unsigned emits_seen;
    int unsigned checked;
    int unsigned mismatches;
    int unsigned unexpected;
    int unsigned reported;

    function new();
      rows_reg  = 5'd1;
      cols_reg  = 5'd1;
      left_reg  = '0;
      right_reg = '0;
      up_reg    = '0;
      down_reg  = '0;
      foreach (loaded[i]) begin
        loaded[i] = 1'b0;
        store[i]  = '0;
      end
      load_pos    = 0;
      emit_r      = 0;
      emit_c      = 0;
      net_left    = 0;
      net_up      = 0;
      latched     = 1'b0;
      writes_seen = 0;
      emits_seen  = 0;
      checked     = 0;
      mismatches  = 0;
      unexpected  = 0;
      reported    = 0;
    endfunction

    function int unsigned clamp_dim(logic [4:0] raw);
      if (raw == 0) return 1;
      if (raw > MAX_DIM) return MAX_DIM;
      return raw;
    endfunction

    function int unsigned rows_used();
      return clamp_dim(rows_reg);
    endfunction

    function int unsigned cols_used();
      return clamp_dim(cols_reg);
    endfunction

    function int unsigned wrap_shift(logic [15:0] fwd, logic [15:0] back, int unsigned dim);
      return ((fwd % dim) + dim - (back % dim)) % dim;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        mcs_pkg::REG_ROWS:  rows_reg  = value[4:0];
        mcs_pkg::REG_COLS:  cols_reg  = value[4:0];
        mcs_pkg::REG_LEFT:  left_reg  = value[15:0];
        mcs_pkg::REG_RIGHT: right_reg = value[15:0];
        mcs_pkg::REG_UP:    up_reg    = value[15:0];
        mcs_pkg::REG_DOWN:  down_reg  = value[15:0];
        default: ;
      endcase
    endfunction

    function bit region_loaded();
      for (int r = 0; r < rows_used(); r++)
        for (int c = 0; c < cols_used(); c++)
          if (!loaded[r*MAX_DIM + c]) return 1'b0;
      return 1'b1;
    endfunction

    function void note_input(logic cmd, logic [31:0] value);
      int unsigned rows;
      int unsigned cols;
      int unsigned total;
      int unsigned addr;
      shifted_elem_t res;
      rows  = rows_used();
      cols  = cols_used();
      total = rows * cols;
      if (cmd == mcs_pkg::CMD_WRITE) begin
        if (load_pos >= total) load_pos = 0;
        addr = (load_pos / cols) * MAX_DIM + (load_pos % cols);
        store[addr]  = value;
        loaded[addr] = 1'b1;
        load_pos = (load_pos + 1 >= total) ? 0 : load_pos + 1;
        latched  = 1'b0;
        emit_r   = 0;
        emit_c   = 0;
        writes_seen++;
        return;
      end
      if (!latched) begin
        net_left = wrap_shift(left_reg, right_reg, cols);
        net_up   = wrap_shift(up_reg, down_reg, rows);
        latched  = 1'b1;
        emit_r   = 0;
        emit_c   = 0;
      end
      if (emit_r >= rows || emit_c >= cols) begin
        emit_r = 0;
        emit_c = 0;
      end
      addr = ((emit_r + net_up) % rows) * MAX_DIM + ((emit_c + net_left) % cols);
      res.element = store[addr];
      res.last    = (emit_r == rows - 1) && (emit_c == cols - 1);
      expected_q.push_back(res);
      emits_seen++;
      if (res.last) begin
        emit_r  = 0;
        emit_c  = 0;
        latched = 1'b0;
      end else if (emit_c + 1 >= cols) begin
        emit_c = 0;
        emit_r++;
      end else begin
        emit_c++;
      end
    endfunction

    function void check_result(logic [31:0] element, logic last);
      shifted_elem_t want;
      if (expected_q.size() == 0) begin
        if (reported < 10)
          $display("unexpected result: element=%h last=%b", element, last);
        reported++;
        unexpected++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (want.element !== element || want.last !== last) begin
        if (reported < 10)
          $display("mismatch at result %0d: expected element=%h last=%b, got element=%h last=%b",
                   checked, want.element, want.last, element, last);
        reported++;
        mismatches++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic signed [31:0] in_tdata;
  logic               in_tuser;
  logic               out_tvalid;
  logic               out_tready;
  logic signed [31:0] out_tdata;
  logic               out_tlast;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [4:0]         cfg_paddr;
  logic [31:0]        cfg_pwdata;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  shift_scoreboard sb;
  int unsigned     tx_idle_pct;
  int unsigned     rx_idle_pct;
  int unsigned     hold_req;
  int unsigned     items_sent;
  int unsigned     settings_applied;
  int unsigned     cycle_count;

  matrix_cyclic_shift u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
      if (in_tvalid && in_tready) sb.note_input(in_tuser, in_tdata);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL matrix_cyclic_shift");
      $finish;
    end
  end

  initial begin
    int unsigned hold_seen;
    int unsigned hold_left;
    out_tready = 1'b0;
    hold_seen  = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [4:0] pick_dim();
    case ($urandom_range(0, 19))
      0: return 5'd0;
      1: return 5'($urandom_range(17, 31));
      2, 3: return 5'($urandom_range(5, 16));
      default: return 5'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [15:0] pick_shift();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      2, 3: return 16'($urandom());
      default: return 16'($urandom_range(0, 40));
    endcase
  endfunction

  task automatic send_item(input logic cmd, input logic [31:0] value);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic load_matrix(input int unsigned count);
    repeat (count) send_item(mcs_pkg::CMD_WRITE, pick_value());
  endtask

  task automatic emit_run(input int unsigned count);
    repeat (count) send_item(mcs_pkg::CMD_EMIT, $urandom());
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.write_reg(idx, value);
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [4:0] rows, input logic [4:0] cols,
                               input logic [15:0] left, input logic [15:0] right,
                               input logic [15:0] up, input logic [15:0] down);
    logic [31:0] junk;
    drain_results();
    repeat (SETTLE) @(negedge clk);
    junk = $urandom();
    cfg_write(mcs_pkg::REG_ROWS,  {junk[31:5], rows});
    cfg_write(mcs_pkg::REG_COLS,  {junk[26:0], cols});
    cfg_write(mcs_pkg::REG_LEFT,  {junk[31:16], left});
    cfg_write(mcs_pkg::REG_RIGHT, {junk[15:0], right});
    cfg_write(mcs_pkg::REG_UP,    {junk[23:8], up});
    cfg_write(mcs_pkg::REG_DOWN,  {junk[7:0], junk[31:24], down});
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    settings_applied++;
  endtask

  task automatic run_episode(input bit press);
    int unsigned total;
    int unsigned kind;
    total = sb.rows_used() * sb.cols_used();
    if (!(sb.region_loaded() && $urandom_range(0, 2) == 0)) load_matrix(total);
    if (press) hold_req++;
    repeat ($urandom_range(1, 3)) begin
      kind = $urandom_range(0, 9);
      if (kind == 7 && total > 1) begin
        emit_run($urandom_range(1, total - 1));
      end else if (kind == 8 && total > 1) begin
        emit_run($urandom_range(1, total - 1));
        send_item(mcs_pkg::CMD_WRITE, pick_value());
        emit_run(total);
      end else if (kind == 9) begin
        emit_run(total + $urandom_range(1, total));
      end else begin
        emit_run(total);
      end
    end
  endtask

  initial begin
    int unsigned goal;
    int unsigned errors;
    rst_n            = 1'b0;
    in_tvalid        = 1'b0;
    in_tdata         = '0;
    in_tuser         = 1'b0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    tx_idle_pct      = 19;
    rx_idle_pct      = 65;
    hold_req         = 0;
    items_sent       = 0;
    settings_applied = 0;
    cycle_count      = 0;
    sb = new();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(mcs_pkg::CMD_WRITE, 32'h8000_0000);
    send_item(mcs_pkg::CMD_EMIT, 32'hffff_ffff);
    send_item(mcs_pkg::CMD_WRITE, 32'h7fff_ffff);
    send_item(mcs_pkg::CMD_EMIT, 32'h0000_0000);
    apply_setting(5'd2, 5'd3, 16'hffff, 16'h0000, 16'h0000, 16'hffff);
    send_item(mcs_pkg::CMD_WRITE, 32'h0000_0000);
    send_item(mcs_pkg::CMD_WRITE, 32'hffff_ffff);
    send_item(mcs_pkg::CMD_WRITE, 32'h8000_0000);
    send_item(mcs_pkg::CMD_WRITE, 32'h7fff_ffff);
    load_matrix(2);
    emit_run(4);
    send_item(mcs_pkg::CMD_WRITE, $urandom());
    emit_run(6);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 19;
          rx_idle_pct = 65;
        end
        1: begin
          tx_idle_pct = 65;
          rx_idle_pct = 19;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      goal = 21 + ITEM_GOAL * (ph + 1) / 3;
      case (ph)
        0: begin
          apply_setting(5'd4, 5'd4, 16'd5, 16'd1, 16'd0, 16'd3);
          run_episode(1'b1);
        end
        1: begin
          apply_setting(5'd16, 5'd16, pick_shift(), pick_shift(), pick_shift(), pick_shift());
          load_matrix(MAX_DIM * MAX_DIM);
          hold_req++;
          emit_run(MAX_DIM * MAX_DIM);
        end
        default: begin
          apply_setting(5'd0, 5'd31, 16'hffff, 16'hffff, 16'h0000, 16'h0000);
          run_episode(1'b0);
        end
      endcase
      while (items_sent < goal) begin
        apply_setting(pick_dim(), pick_dim(), pick_shift(), pick_shift(), pick_shift(),
                      pick_shift());
        repeat ($urandom_range(1, 3)) run_episode($urandom_range(0, 29) == 0);
      end
    end

    drain_results();
    repeat (SETTLE) @(negedge clk);

    errors = sb.mismatches + sb.unexpected + sb.expected_q.size();
    $display("covered %0d register settings, %0d element writes and %0d emits in %0d cycles",
             settings_applied, sb.writes_seen, sb.emits_seen, cycle_count);
    $display("checked %0d results: %0d mismatches, %0d unexpected, %0d missing",
             sb.checked, sb.mismatches, sb.unexpected, sb.expected_q.size());
    if (errors == 0) begin
      $display("PASS matrix_cyclic_shift");
    end else begin
      $display("FAIL matrix_cyclic_shift");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/mcs_pkg.sv
src/mcs_regs.sv
src/mcs_div.sv
src/mcs_dp.sv
src/mcs_ctrl.sv
src/matrix_cyclic_shift.sv
bench/tb_top.sv
